// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/ssed_pkg.sv =====
`timescale 1ns / 1ps

package ssed_pkg;

  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int LIMIT_W    = 15;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int X_W        = 10;
  localparam int Y_W        = 12;
  localparam int MAX_HEIGHT = 4096;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_CONTRAST = 2'd2;

  typedef struct packed {
    logic no_greater;
    logic no_less;
  } lane_flags_t;

  typedef struct packed {
    logic           valid;
    logic           emit_ok;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } pipe_meta_t;

endpackage

// ===== rtl/ssed_ifs.sv =====
`timescale 1ns / 1ps

interface ssed_in_if #(parameter int SAMPLE_BITS = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_below;
  logic signed [SAMPLE_BITS-1:0] sample_mid;
  logic signed [SAMPLE_BITS-1:0] sample_above;
  logic                          first_of_frame;

  modport source(output valid, sample_below, sample_mid, sample_above, first_of_frame,
                 input ready);
  modport sink(input valid, sample_below, sample_mid, sample_above, first_of_frame,
               output ready);
endinterface

interface ssed_out_if #(parameter int SAMPLE_BITS = 16) ();
  logic                          valid;
  logic                          ready;
  logic [ssed_pkg::X_W-1:0]      cand_x;
  logic [ssed_pkg::Y_W-1:0]      cand_y;
  logic signed [SAMPLE_BITS-1:0] cand_value;
  logic                          is_maximum;
  logic                          is_minimum;

  modport source(output valid, cand_x, cand_y, cand_value, is_maximum, is_minimum,
                 input ready);
  modport sink(input valid, cand_x, cand_y, cand_value, is_maximum, is_minimum,
               output ready);
endinterface

interface ssed_cfg_if ();
  logic                            valid;
  logic                            ready;
  logic [ssed_pkg::CFG_IDX_W-1:0]  index;
  logic [ssed_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/ssed_lane.sv =====
`timescale 1ns / 1ps

module ssed_lane #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic [$clog2(MAX_WIDTH)-1:0]        addr,
  input  logic signed [SAMPLE_BITS-1:0]       fresh,
  input  logic signed [SAMPLE_BITS-1:0]       centre,
  output logic signed [SAMPLE_BITS-1:0]       centre_out,
  output ssed_pkg::lane_flags_t               flags_r
);
  import ssed_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SB = SAMPLE_BITS;

  // one entry per column: {two rows up, one row up}
  logic [2*SB-1:0]       mem [MAX_WIDTH];
  logic [2*SB-1:0]       rd_raw_r;
  logic [2*SB-1:0]       byp_data_r;
  logic                  byp_r;
  logic [2*SB-1:0]       rd_word;
  logic [2*SB-1:0]       wr_word;
  logic                  s1_valid_r;
  logic [CW-1:0]         s1_addr_r;
  logic signed [SB-1:0]  s1_fresh_r;
  logic signed [SB-1:0]  win_r [3][3];
  lane_flags_t           flags_nxt;

  assign rd_word = byp_r ? byp_data_r : rd_raw_r;
  assign wr_word = {rd_word[SB-1:0], s1_fresh_r};

  // read-modify-write; same column back to back forwards the pending write
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      mem[s1_addr_r] <= wr_word;
    end
    if (accept) begin
      rd_raw_r   <= mem[addr];
      byp_r      <= s1_valid_r && (s1_addr_r == addr);
      byp_data_r <= wr_word;
      s1_addr_r  <= addr;
      s1_fresh_r <= fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  // rows: 0 oldest, 2 current; column 2 newest
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= $signed(rd_word[2*SB-1:SB]);
      win_r[1][2] <= $signed(rd_word[SB-1:0]);
      win_r[2][2] <= s1_fresh_r;
    end
  end

  assign centre_out = win_r[1][1];

  always_comb begin
    flags_nxt.no_greater = 1'b1;
    flags_nxt.no_less    = 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (win_r[i][j] > centre) flags_nxt.no_greater = 1'b0;
        if (win_r[i][j] < centre) flags_nxt.no_less    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    flags_r <= flags_nxt;
  end

endmodule

// ===== rtl/ssed_merge.sv =====
`timescale 1ns / 1ps

module ssed_merge #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ssed_pkg::pipe_meta_t           s2_meta,
  input  logic signed [SAMPLE_BITS-1:0]  centre,
  input  ssed_pkg::lane_flags_t          lane_flags [3],
  input  logic [ssed_pkg::LIMIT_W-1:0]   limit,
  output logic                           s3_valid,
  output logic                           push,
  output logic [ssed_pkg::X_W-1:0]       res_x,
  output logic [ssed_pkg::Y_W-1:0]       res_y,
  output logic signed [SAMPLE_BITS-1:0]  res_value,
  output logic                           res_max,
  output logic                           res_min
);
  import ssed_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int CMPW = ((SB > LIMIT_W) ? SB : LIMIT_W) + 1;

  pipe_meta_t           s3_meta_r;
  logic signed [SB-1:0] s3_centre_r;
  logic [CMPW-1:0]      centre_ext;
  logic [CMPW-1:0]      mag;
  logic [CMPW-1:0]      limit_ext;
  logic                 all_max;
  logic                 all_min;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_meta_r <= '0;
    end else begin
      s3_meta_r <= s2_meta;
    end
  end

  always_ff @(posedge clk) begin
    s3_centre_r <= centre;
  end

  always_comb begin
    centre_ext = {{(CMPW-SB){s3_centre_r[SB-1]}}, s3_centre_r};
    mag        = centre_ext[CMPW-1] ? (~centre_ext + CMPW'(1)) : centre_ext;
    limit_ext  = CMPW'(limit);
    all_max    = lane_flags[0].no_greater && lane_flags[1].no_greater &&
                 lane_flags[2].no_greater;
    all_min    = lane_flags[0].no_less && lane_flags[1].no_less && lane_flags[2].no_less;
  end

  assign s3_valid  = s3_meta_r.valid;
  assign push      = s3_meta_r.valid && s3_meta_r.emit_ok && (mag >= limit_ext) &&
                     (all_max || all_min);
  assign res_x     = s3_meta_r.x;
  assign res_y     = s3_meta_r.y;
  assign res_value = s3_centre_r;
  assign res_max   = all_max;
  assign res_min   = all_min;

endmodule

// ===== rtl/ssed_out_fifo.sv =====
`timescale 1ns / 1ps

module ssed_out_fifo #(
  parameter int W = 40
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  logic [W-1:0]                    push_data,
  input  logic                            pop,
  output logic                            head_valid,
  output logic [W-1:0]                    head_data,
  output logic [ssed_pkg::FIFO_CNT_W-1:0] count
);
  import ssed_pkg::*;

  logic [W-1:0]          buf_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic [FIFO_CNT_W-1:0] count_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + FIFO_CNT_W'(1);
    if (pop && !push) count_nxt = count_r - FIFO_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_data  = buf_r[rd_ptr_r];
  assign count      = count_r;

endmodule

// ===== rtl/scale_space_extremum_detect.sv =====
// channel  | dir | handshake         | payload
// cfg_ch   | in  | valid/ready       | index, data (frame_width, frame_height, limit)
// in_ch    | in  | valid/ready       | sample_below, sample_mid, sample_above, first_of_frame
// out_ch   | out | valid/ready       | cand_x, cand_y, cand_value, is_maximum, is_minimum
//
// One pixel per cycle sustained while in_ch.ready is high; a candidate reaches out_ch
// once its pixel has passed line store read-modify-write, window compare and merge.
// Synchronous active-low reset clears position, pipeline and result FIFO and restores
// register defaults; line stores are not cleared.
// in_ch.ready drops only when the eight-entry result FIFO plus items in flight are full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scale_space_extremum_detect #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  ssed_cfg_if.sink   cfg_ch,
  ssed_in_if.sink    in_ch,
  ssed_out_if.source out_ch
);
  import ssed_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int SB  = SAMPLE_BITS;
  localparam int WCW = ((CW + 1) > FW_W) ? (CW + 1) : FW_W;
  localparam int RW  = X_W + Y_W + SB + 2;

  logic [FW_W-1:0]    frame_width_r;
  logic [FH_W-1:0]    frame_height_r;
  logic [LIMIT_W-1:0] limit_r;

  logic [WCW-1:0]  fw_ext;
  logic [WCW-1:0]  w_use;
  logic [FH_W-1:0] h_use;

  logic [CW-1:0]  col_r, col_nxt, c0, c1, xm;
  logic [Y_W-1:0] row_r, row_nxt, r0, r2, ym;
  logic [Y_W:0]   r1, rn;
  logic [CW:0]    cn;
  logic           emit_ok;
  logic           accept;

  pipe_meta_t s1_meta_r;
  pipe_meta_t s2_meta_r;

  lane_flags_t          lane_flags [3];
  logic signed [SB-1:0] lane_centre [3];
  logic signed [SB-1:0] centre;

  logic                  s3_valid;
  logic                  merge_push;
  logic [X_W-1:0]        res_x;
  logic [Y_W-1:0]        res_y;
  logic signed [SB-1:0]  res_value;
  logic                  res_max;
  logic                  res_min;
  logic [RW-1:0]         head_data;
  logic                  head_valid;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W-1:0] inflight;
  logic [FIFO_CNT_W:0]   occupancy;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
      limit_r        <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_ch.data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_ch.data[FH_W-1:0];
        REG_LOW_CONTRAST: limit_r        <= cfg_ch.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fw_ext = WCW'(frame_width_r);
    if (fw_ext < WCW'(3))              w_use = WCW'(3);
    else if (fw_ext > WCW'(MAX_WIDTH)) w_use = WCW'(MAX_WIDTH);
    else                               w_use = fw_ext;
    if (frame_height_r < FH_W'(3))               h_use = FH_W'(3);
    else if (frame_height_r > FH_W'(MAX_HEIGHT)) h_use = FH_W'(MAX_HEIGHT);
    else                                         h_use = frame_height_r;
  end

  // raster position of the incoming pixel, and of the one after it
  always_comb begin
    c0 = in_ch.first_of_frame ? '0 : col_r;
    r0 = in_ch.first_of_frame ? '0 : row_r;
    if (WCW'(c0) >= w_use) begin
      c1 = '0;
      r1 = {1'b0, r0} + (Y_W+1)'(1);
    end else begin
      c1 = c0;
      r1 = {1'b0, r0};
    end
    r2 = (r1 >= h_use) ? '0 : r1[Y_W-1:0];

    cn = {1'b0, c1} + (CW+1)'(1);
    rn = {1'b0, r2} + (Y_W+1)'(1);
    if (WCW'(cn) >= w_use) begin
      col_nxt = '0;
      row_nxt = (rn >= h_use) ? '0 : rn[Y_W-1:0];
    end else begin
      col_nxt = cn[CW-1:0];
      row_nxt = r2;
    end

    emit_ok = (c1 >= CW'(2)) && (r2 >= Y_W'(2));
    xm      = c1 - CW'(1);
    ym      = r2 - Y_W'(1);
  end

  assign occupancy   = (FIFO_CNT_W+1)'(fifo_count) + (FIFO_CNT_W+1)'(inflight);
  assign in_ch.ready = (occupancy < (FIFO_CNT_W+1)'(FIFO_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      s1_meta_r <= '0;
      s2_meta_r <= '0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      s1_meta_r.valid   <= accept;
      s1_meta_r.emit_ok <= emit_ok;
      s1_meta_r.x       <= X_W'(xm);
      s1_meta_r.y       <= ym;
      s2_meta_r         <= s1_meta_r;
    end
  end

  // one lane per scale; the searched scale supplies the centre
  assign centre = lane_centre[1];

  ssed_lane #(.MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SB)) u_lane_below (
    .clk(clk), .rst_n(rst_n), .accept(accept), .addr(c1), .fresh(in_ch.sample_below),
    .centre(centre), .centre_out(lane_centre[0]), .flags_r(lane_flags[0])
  );

  ssed_lane #(.MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SB)) u_lane_mid (
    .clk(clk), .rst_n(rst_n), .accept(accept), .addr(c1), .fresh(in_ch.sample_mid),
    .centre(centre), .centre_out(lane_centre[1]), .flags_r(lane_flags[1])
  );

  ssed_lane #(.MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SB)) u_lane_above (
    .clk(clk), .rst_n(rst_n), .accept(accept), .addr(c1), .fresh(in_ch.sample_above),
    .centre(centre), .centre_out(lane_centre[2]), .flags_r(lane_flags[2])
  );

  ssed_merge #(.SAMPLE_BITS(SB)) u_merge (
    .clk(clk), .rst_n(rst_n), .s2_meta(s2_meta_r), .centre(centre),
    .lane_flags(lane_flags), .limit(limit_r), .s3_valid(s3_valid), .push(merge_push),
    .res_x(res_x), .res_y(res_y), .res_value(res_value), .res_max(res_max),
    .res_min(res_min)
  );

  assign inflight = FIFO_CNT_W'(s1_meta_r.valid) + FIFO_CNT_W'(s2_meta_r.valid) +
                    FIFO_CNT_W'(s3_valid);

  ssed_out_fifo #(.W(RW)) u_out_fifo (
    .clk(clk), .rst_n(rst_n), .push(merge_push),
    .push_data({res_x, res_y, res_value, res_max, res_min}),
    .pop(out_ch.valid && out_ch.ready), .head_valid(head_valid), .head_data(head_data),
    .count(fifo_count)
  );

  assign out_ch.valid      = head_valid;
  assign out_ch.cand_x     = head_data[RW-1 -: X_W];
  assign out_ch.cand_y     = head_data[RW-X_W-1 -: Y_W];
  assign out_ch.cand_value = $signed(head_data[SB+1:2]);
  assign out_ch.is_maximum = head_data[1];
  assign out_ch.is_minimum = head_data[0];

  `ASSERT_ALWAYS(a_room, clk, rst_n, occupancy <= (FIFO_CNT_W+1)'(FIFO_DEPTH), "result FIFO overbooked")
  `ASSERT_IMPLIES(a_push_space, clk, rst_n, merge_push, fifo_count < FIFO_CNT_W'(FIFO_DEPTH), "push into full FIFO")
  `ASSERT_IMPLIES(a_interior_row, clk, rst_n, out_ch.valid, out_ch.cand_y != '0, "candidate on border row")
  `ASSERT_IMPLIES(a_kind, clk, rst_n, out_ch.valid, out_ch.is_maximum || out_ch.is_minimum, "candidate neither max nor min")

endmodule

// ===== bench/ssed_candidate_checker.sv =====
`timescale 1ns / 1ps

module ssed_candidate_checker
  import ssed_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_below,
  input  logic signed [SAMPLE_BITS-1:0] in_mid,
  input  logic signed [SAMPLE_BITS-1:0] in_above,
  input  logic                          in_first,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [X_W-1:0]                out_x,
  input  logic [Y_W-1:0]                out_y,
  input  logic signed [SAMPLE_BITS-1:0] out_value,
  input  logic                          out_max,
  input  logic                          out_min,
  output int                            mismatch_count,
  output int                            cands_waiting
);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [X_W-1:0]         x;
    logic [Y_W-1:0]         y;
    logic [SAMPLE_BITS-1:0] value;
    logic                   is_max;
    logic                   is_min;
  } cand_t;

  // line_rows[scale][0] holds the previous row, [1] the one before it
  sample_t            line_rows [3][2][MAX_WIDTH];
  // cube[scale][row][col], col 2 newest, row 2 current
  sample_t            cube [3][3][3];
  logic [FW_W-1:0]    width_reg;
  logic [FH_W-1:0]    height_reg;
  logic [LIMIT_W-1:0] limit_reg;
  int unsigned        col_pos;
  int unsigned        row_pos;
  cand_t              expected_cands [$];

  task automatic search_cube(input sample_t s_below, input sample_t s_mid,
                             input sample_t s_above, input logic first);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int          s;
    int          i;
    int          j;
    int          mag;
    sample_t     fresh [3];
    sample_t     centre;
    logic        no_greater;
    logic        no_less;
    cand_t       cand;
    w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg < 3) ? 3 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    c = col_pos;
    r = row_pos;
    fresh[0] = s_below;
    fresh[1] = s_mid;
    fresh[2] = s_above;
    if (first) begin
      c = 0;
      r = 0;
    end
    // stale position after a register change wraps before use
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;

    for (s = 0; s < 3; s++) begin
      for (i = 0; i < 3; i++) begin
        cube[s][i][0] = cube[s][i][1];
        cube[s][i][1] = cube[s][i][2];
      end
      cube[s][0][2] = line_rows[s][1][c];
      cube[s][1][2] = line_rows[s][0][c];
      cube[s][2][2] = fresh[s];
      line_rows[s][1][c] = line_rows[s][0][c];
      line_rows[s][0][c] = fresh[s];
    end

    if (c >= 2 && r >= 2) begin
      centre = cube[1][1][1];
      mag = (centre < 0) ? -int'(centre) : int'(centre);
      if (mag >= int'(limit_reg)) begin
        no_greater = 1'b1;
        no_less    = 1'b1;
        for (s = 0; s < 3; s++)
          for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++) begin
              if (cube[s][i][j] > centre) no_greater = 1'b0;
              if (cube[s][i][j] < centre) no_less = 1'b0;
            end
        if (no_greater || no_less) begin
          cand.x      = X_W'(c - 1);
          cand.y      = Y_W'(r - 1);
          cand.value  = centre;
          cand.is_max = no_greater;
          cand.is_min = no_less;
          expected_cands = {expected_cands, cand};
        end
      end
    end

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  always @(posedge clk) begin : watch
    cand_t got;
    cand_t want;
    int    s;
    int    i;
    int    j;
    if (!rst_n) begin
      width_reg  = FW_RESET;
      height_reg = FH_RESET;
      limit_reg  = '0;
      col_pos    = 0;
      row_pos    = 0;
      for (s = 0; s < 3; s++)
        for (i = 0; i < 3; i++)
          for (j = 0; j < 3; j++)
            cube[s][i][j] = '0;
      expected_cands.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_reg = cfg_data[FW_W-1:0];
          REG_FRAME_HEIGHT: height_reg = cfg_data[FH_W-1:0];
          REG_LOW_CONTRAST: limit_reg = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) search_cube(in_below, in_mid, in_above, in_first);

      if (out_valid && out_ready) begin
        got.x      = out_x;
        got.y      = out_y;
        got.value  = out_value;
        got.is_max = out_max;
        got.is_min = out_min;
        if (expected_cands.size() == 0) begin
          mismatch_count++;
          $display("%t unexpected candidate: got x=%0d y=%0d value=%0d max=%b min=%b",
                   $time, got.x, got.y, $signed(got.value), got.is_max, got.is_min);
        end else begin
          want = expected_cands.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.value !== want.value ||
              got.is_max !== want.is_max || got.is_min !== want.is_min) begin
            mismatch_count++;
            $display({"%t candidate mismatch: expected x=%0d y=%0d value=%0d max=%b",
                      " min=%b, got x=%0d y=%0d value=%0d max=%b min=%b"},
                     $time, want.x, want.y, $signed(want.value), want.is_max,
                     want.is_min, got.x, got.y, $signed(got.value), got.is_max,
                     got.is_min);
          end
        end
      end
    end
    cands_waiting = expected_cands.size();
  end

endmodule

// ===== bench/scale_space_extremum_detect_tb.sv =====
`timescale 1ns / 1ps

module scale_space_extremum_detect_tb;
  import ssed_pkg::*;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_WIDTH   = 1024;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   cur_w;
  int   cur_h;
  int   mismatch_count;
  int   cands_waiting;

  ssed_cfg_if                              cfg_ch ();
  ssed_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  ssed_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  scale_space_extremum_detect #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  ssed_candidate_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_ch.valid),
    .cfg_ready     (cfg_ch.ready),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_below      (in_ch.sample_below),
    .in_mid        (in_ch.sample_mid),
    .in_above      (in_ch.sample_above),
    .in_first      (in_ch.first_of_frame),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_x         (out_ch.cand_x),
    .out_y         (out_ch.cand_y),
    .out_value     (out_ch.cand_value),
    .out_max       (out_ch.is_maximum),
    .out_min       (out_ch.is_minimum),
    .mismatch_count(mismatch_count),
    .cands_waiting (cands_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // caller lowers cfg valid after the last write of a group
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results(input int extra);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (cands_waiting != 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] w_raw,
                           input logic [CFG_DATA_W-1:0] h_raw,
                           input logic [CFG_DATA_W-1:0] limit);
    drain_results(8);
    write_reg(REG_FRAME_WIDTH, w_raw);
    write_reg(REG_FRAME_HEIGHT, h_raw);
    write_reg(REG_LOW_CONTRAST, limit);
    cfg_ch.valid <= 1'b0;
    cur_w = int'(w_raw[FW_W-1:0]);
    cur_w = (cur_w < 3) ? 3 : (cur_w > MAX_WIDTH) ? MAX_WIDTH : cur_w;
    cur_h = int'(h_raw[FH_W-1:0]);
    cur_h = (cur_h < 3) ? 3 : (cur_h > MAX_HEIGHT) ? MAX_HEIGHT : cur_h;
  endtask

  // entered and left at a falling edge; valid stays high for a back-to-back request
  task automatic send_pixel(input sample_t below, input sample_t mid, input sample_t above,
                            input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.sample_below   <= below;
    in_ch.sample_mid     <= mid;
    in_ch.sample_above   <= above;
    in_ch.first_of_frame <= first;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic sample_t pick_sample(input int mode);
    case (mode)
      0: return sample_t'($urandom);
      1: return sample_t'($urandom_range(4)) - sample_t'(2);   // tight range, many ties
      2: begin
        case ($urandom_range(6))
          0: return 16'sh8000;
          1: return 16'sh8001;
          2: return -16'sd1;
          3: return 16'sd0;
          4: return 16'sd1;
          5: return 16'sh7FFE;
          default: return 16'sh7FFF;
        endcase
      end
      default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  // 3x3 frame: item 4 is the only interior centre, item 0 carries a value in the scale above
  task automatic directed_frame(input sample_t centre, input sample_t corner, input sample_t rest);
    int k;
    for (k = 0; k < 9; k++)
      send_pixel(rest, (k == 4) ? centre : rest, (k == 0) ? corner : rest, k == 0);
  endtask

  task automatic run_phase(input int budget);
    int sent;
    int seq_idx;
    int seq_len;
    int mode;
    int k;
    int frame_items;
    int hold_at;
    sent        = 0;
    seq_idx     = 0;
    frame_items = cur_w * cur_h;
    hold_at     = $urandom_range(budget - 1);
    while (sent < budget) begin
      mode = $urandom_range(3);
      if (seq_idx == 0) seq_len = frame_items;
      else begin
        case ($urandom_range(9))
          0, 1: seq_len = $urandom_range(frame_items - 1, 1);   // frame cut short
          2:    seq_len = 2 * frame_items;                      // rolls over the last row
          default: seq_len = frame_items;
        endcase
      end
      for (k = 0; k < seq_len && sent < budget; k++) begin
        if (sent == hold_at) drain_results(0);
        send_pixel(pick_sample(mode), pick_sample(mode), pick_sample(mode),
                   (k == 0) || ($urandom_range(199) == 0));
        sent++;
      end
      seq_idx++;
    end
  endtask

  initial begin
    send_idle_pct         = 32;
    recv_idle_pct         = 69;
    cur_w                 = 640;
    cur_h                 = 480;
    rst_n                 = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = REG_FRAME_WIDTH;
    cfg_ch.data           = '0;
    in_ch.valid           = 1'b0;
    in_ch.sample_below    = '0;
    in_ch.sample_mid      = '0;
    in_ch.sample_above    = '0;
    in_ch.first_of_frame  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    configure(3, 3, 0);
    directed_frame(16'sd0, 16'sd0, 16'sd0);            // flat: both max and min
    directed_frame(16'sh8000, 16'sh7FFF, 16'sh7FFF);   // most negative centre
    directed_frame(16'sh7FFF, 16'sh7FFF, 16'sh8000);   // max with a tie in the scale above

    configure(0, 13'h1FFF, 0);
    run_phase(150);
    configure(7, 5, CFG_DATA_W'($urandom_range(3)));
    run_phase(200);
    configure(CFG_DATA_W'($urandom_range(40, 3)), CFG_DATA_W'($urandom_range(12, 3)),
              CFG_DATA_W'($urandom_range(40)));
    run_phase(200);

    send_idle_pct = 69;
    recv_idle_pct = 32;
    configure(15'h7FFF, 0, 0);
    run_phase(100);
    configure(CFG_DATA_W'($urandom_range(64, 3)), CFG_DATA_W'($urandom_range(16, 3)),
              15'h7FFF);
    run_phase(200);
    configure(5, 4, 1);
    run_phase(100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(CFG_DATA_W'($urandom_range(20, 3)), CFG_DATA_W'($urandom_range(10, 3)),
              CFG_DATA_W'($urandom_range(2)));
    run_phase(200);
    configure(3, 3, 0);
    run_phase(150);

    drain_results(10);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ssed_pkg.sv
rtl/ssed_ifs.sv
rtl/ssed_lane.sv
rtl/ssed_merge.sv
rtl/ssed_out_fifo.sv
rtl/scale_space_extremum_detect.sv
bench/ssed_candidate_checker.sv
bench/scale_space_extremum_detect_tb.sv
